>>> sv/untp_pkg.sv
// Package for the unsigned number text parser: character codes, base constants
// and the digit and whitespace decoders. It has no dependencies.
package untp_pkg;

   localparam int BaseBits = 6;
   localparam int CharBits = 8;
   localparam int DigitBits = 6;

   localparam logic [DigitBits-1:0] NotDigit = 6'd40;
   localparam logic [BaseBits-1:0] MaxBase = 6'd36;
   localparam logic [BaseBits-1:0] HexBase = 6'd16;
   localparam logic [BaseBits-1:0] DecBase = 6'd10;
   localparam logic [BaseBits-1:0] OctBase = 6'd8;
   localparam logic [BaseBits-1:0] AutoBase = 6'd0;
   localparam logic [BaseBits-1:0] UnaryBase = 6'd1;

   localparam logic [CharBits-1:0] CharZero = 8'h30;
   localparam logic [CharBits-1:0] CharNine = 8'h39;
   localparam logic [CharBits-1:0] CharLowA = 8'h61;
   localparam logic [CharBits-1:0] CharLowZ = 8'h7A;
   localparam logic [CharBits-1:0] CharUpA = 8'h41;
   localparam logic [CharBits-1:0] CharUpZ = 8'h5A;
   localparam logic [CharBits-1:0] CharLowX = 8'h78;
   localparam logic [CharBits-1:0] CharUpX = 8'h58;
   localparam logic [CharBits-1:0] CharSpace = 8'h20;
   localparam logic [CharBits-1:0] CharTab = 8'h09;
   localparam logic [CharBits-1:0] CharCr = 8'h0D;

   // Space, TAB, LF, VT, FF and CR count as whitespace.
   function automatic logic is_space(input logic [CharBits-1:0] c);
      return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
   endfunction

   // Digit value of a character in any base up to 36, or NotDigit.
   function automatic logic [DigitBits-1:0] digit_of(input logic [CharBits-1:0] c);
      logic [DigitBits-1:0] d;
      d = NotDigit;
      if ((c >= CharZero) && (c <= CharNine)) begin
         d = DigitBits'(c - CharZero);
      end else if ((c >= CharLowA) && (c <= CharLowZ)) begin
         d = DigitBits'(c - CharLowA) + DecBase;
      end else if ((c >= CharUpA) && (c <= CharUpZ)) begin
         d = DigitBits'(c - CharUpA) + DecBase;
      end
      return d;
   endfunction

endpackage

>>> sv/unsigned_number_text_parser_core.sv
// A result is registered: it appears in the cycle after its character transaction is accepted.
// Throughput: one character per cycle while no result is stalled; the digit multiply-add
// and the phase logic sit between the parse state registers and the result register.
// A new character is taken while the result register is empty or being drained.
// Synchronous active-high reset returns the parser to the ended state with value,
// offset and base cleared, and empties the result register.

// Top level of the streaming unsigned number text parser.
// Depends on untp_pkg for character codes, base constants and digit decoding.
module unsigned_number_text_parser_core #(
   parameter int VALUE_BITS = 32,
   parameter int POS_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [untp_pkg::CharBits-1:0] req_tdata,   // ch
   input  logic [untp_pkg::BaseBits:0] req_tuser,      // first, base_sel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // value, end_offset, base_used, zero fill
   output logic [((VALUE_BITS + POS_BITS + untp_pkg::BaseBits + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [0:0] rsp_tuser                          // done_res
);
   import untp_pkg::*;

   localparam int RspBits = ((VALUE_BITS + POS_BITS + BaseBits + 7) / 8) * 8;
   localparam int ProdBits = VALUE_BITS + BaseBits;

   typedef enum logic [1:0] {PhDone, PhSpace, PhPrefix, PhDigits} phase_type;

   phase_type phase_ff, phase_in, ph_s;
   logic [BaseBits-1:0] cur_base_ff, cur_base_in, base_s, base_dig;
   logic [VALUE_BITS-1:0] accum_ff, accum_in, acc_s;
   logic [POS_BITS-1:0] char_pos_ff, char_pos_in, pos_s, next_pos;
   logic [POS_BITS-1:0] end_pos_ff, end_pos_in, end_s;
   logic [ProdBits-1:0] prod;
   logic [DigitBits-1:0] digit;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RspBits-1:0] rsp_data_ff;
   logic rsp_done_ff;

   logic accept, first, illegal, digit_ok;
   logic [BaseBits-1:0] base_sel;
   logic [CharBits-1:0] ch;

   assign ch = req_tdata;
   assign first = req_tuser[0];
   assign base_sel = req_tuser[BaseBits:1];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   // A first character restarts the parse before the character itself is looked at.
   assign illegal = (base_sel == UnaryBase) || (base_sel > MaxBase);
   assign ph_s = first ? (illegal ? PhDone : PhSpace) : phase_ff;
   assign base_s = first ? base_sel : cur_base_ff;
   assign acc_s = first ? '0 : accum_ff;
   assign pos_s = first ? (illegal ? POS_BITS'(1) : '0) : char_pos_ff;
   assign end_s = first ? '0 : end_pos_ff;

   assign next_pos = (pos_s == '1) ? pos_s : pos_s + POS_BITS'(1);

   // Automatic base falls back to decimal when the first non-space is not a zero.
   assign base_dig = ((ph_s == PhSpace) && (base_s == AutoBase)) ? DecBase : base_s;
   assign digit = digit_of(ch);
   assign digit_ok = digit < base_dig;
   assign prod = ProdBits'(acc_s) * ProdBits'(base_dig) + ProdBits'(digit);

   always_comb begin
      phase_in = ph_s;
      cur_base_in = base_s;
      accum_in = acc_s;
      char_pos_in = pos_s;
      end_pos_in = end_s;
      if (ph_s != PhDone) begin
         char_pos_in = next_pos;
         case (ph_s)
            PhSpace: begin
               if (is_space(ch)) begin
                  phase_in = PhSpace;
               end else if ((base_s == HexBase || base_s == AutoBase) && ch == CharZero) begin
                  if (base_s == AutoBase) begin
                     cur_base_in = OctBase;
                  end
                  end_pos_in = next_pos;
                  phase_in = PhPrefix;
               end else begin
                  cur_base_in = base_dig;
                  if (digit_ok) begin
                     accum_in = prod[VALUE_BITS-1:0];
                     end_pos_in = next_pos;
                     phase_in = PhDigits;
                  end else begin
                     phase_in = PhDone;
                  end
               end
            end
            PhPrefix: begin
               if (ch == CharLowX || ch == CharUpX) begin
                  cur_base_in = HexBase;
                  phase_in = PhDigits;
               end else if (digit_ok) begin
                  accum_in = prod[VALUE_BITS-1:0];
                  end_pos_in = next_pos;
                  phase_in = PhDigits;
               end else begin
                  phase_in = PhDone;
               end
            end
            default: begin
               if (digit_ok) begin
                  accum_in = prod[VALUE_BITS-1:0];
                  end_pos_in = next_pos;
                  phase_in = PhDigits;
               end else begin
                  phase_in = PhDone;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhDone;
         cur_base_ff <= '0;
         accum_ff <= '0;
         char_pos_ff <= '0;
         end_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            cur_base_ff <= cur_base_in;
            accum_ff <= accum_in;
            char_pos_ff <= char_pos_in;
            end_pos_ff <= end_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= RspBits'({cur_base_in, end_pos_in, accum_in});
         rsp_done_ff <= (phase_in == PhDone);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_done_ff;

   // An illegal base ends the string at once with a cleared value and offset.
   a_illegal_base: assert property (@(posedge clock) disable iff (reset)
      (accept && first && illegal) |=>
         (rsp_valid_ff && rsp_done_ff && rsp_data_ff[VALUE_BITS+POS_BITS-1:0] == '0))
      else $error("illegal base did not end the parse with a zero result");

   // Once ended, characters without a new start leave the parse state alone.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !first && phase_ff == PhDone) |=>
         ($stable(accum_ff) && $stable(end_pos_ff) && $stable(cur_base_ff)))
      else $error("parse state changed after the end of the string");

   // The end pointer never passes the character position.
   a_end_le_pos: assert property (@(posedge clock) disable iff (reset)
      end_pos_ff <= char_pos_ff)
      else $error("end offset ahead of character position");

   // Past the prefix or in the digits the base has been resolved.
   a_base_known: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PhPrefix || phase_ff == PhDigits) |-> (cur_base_ff != AutoBase))
      else $error("base still automatic after prefix or digits");

   // A stalled result blocks the input side.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while a result was stalled");

endmodule

>>> dv/tb.sv
// Self-checking testbench for unsigned_number_text_parser_core: streams strings one
// character at a time and checks every result against a cycle-free parser model.
// Depends on untp_pkg and the core module.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import untp_pkg::*;

   localparam int ValueBits = 32;
   localparam int PosBits = 8;
   localparam int RspBits = ((ValueBits + PosBits + BaseBits + 7) / 8) * 8;
   localparam int WatchdogLimit = 2000;
   localparam int ReportLimit = 10;

   typedef enum logic [2:0] {
      PhDone   = 3'd0,
      PhSpace  = 3'd1,
      PhPrefix = 3'd2,
      PhDigits = 3'd3
   } parse_phase_type;

   typedef struct packed {
      logic [ValueBits-1:0] value;
      logic [PosBits-1:0] end_offset;
      logic [BaseBits-1:0] base_used;
      logic done;
   } parse_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [CharBits-1:0] req_tdata;     // ch
   logic [BaseBits:0] req_tuser;       // first, base_sel
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RspBits-1:0] rsp_tdata;      // value, end_offset, base_used, zero fill
   logic [0:0] rsp_tuser;              // done_res

   // Parser model state.
   parse_phase_type prs_phase;
   logic [BaseBits-1:0] prs_base;
   logic [ValueBits-1:0] prs_accum;
   logic [PosBits-1:0] prs_char_pos;
   logic [PosBits-1:0] prs_end_pos;

   parse_result_type expected_results[$];
   logic [CharBits-1:0] run_text[$];
   int unsigned sent_chars;
   int unsigned fail_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned stall_cycles;

   unsigned_number_text_parser_core #(
      .VALUE_BITS(ValueBits),
      .POS_BITS(PosBits)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic is_blank(input logic [CharBits-1:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [DigitBits-1:0] char_digit(input logic [CharBits-1:0] c);
      if (c >= "0" && c <= "9") return DigitBits'(c - "0");
      if (c >= "a" && c <= "z") return DigitBits'(c - "a" + 10);
      if (c >= "A" && c <= "Z") return DigitBits'(c - "A" + 10);
      return NotDigit;
   endfunction

   function automatic void take_digit(input logic [CharBits-1:0] c,
                                      input logic [PosBits-1:0] next_pos);
      logic [DigitBits-1:0] d;
      d = char_digit(c);
      if (d >= prs_base) begin
         prs_phase = PhDone;
      end else begin
         prs_accum = ValueBits'(prs_accum * ValueBits'(prs_base) + ValueBits'(d));
         prs_end_pos = next_pos;
         prs_phase = PhDigits;
      end
   endfunction

   // Advances the parser model by one character and returns the result it reports.
   function automatic parse_result_type parse_char(input logic [CharBits-1:0] c,
                                                   input logic first,
                                                   input logic [BaseBits-1:0] bsel);
      logic [PosBits-1:0] next_pos;
      parse_result_type r;
      if (first) begin
         prs_base = bsel;
         prs_accum = '0;
         prs_char_pos = '0;
         prs_end_pos = '0;
         if (bsel == UnaryBase || bsel > MaxBase) begin
            prs_phase = PhDone;
            prs_char_pos = PosBits'(1);
         end else begin
            prs_phase = PhSpace;
         end
      end
      if (prs_phase != PhDone) begin
         next_pos = (prs_char_pos != '1) ? prs_char_pos + PosBits'(1) : prs_char_pos;
         case (prs_phase)
            PhSpace: begin
               if (is_blank(c)) begin
                  // Leading whitespace is skipped.
               end else if (prs_base == HexBase && c == CharZero) begin
                  prs_end_pos = next_pos;
                  prs_phase = PhPrefix;
               end else if (prs_base == AutoBase) begin
                  if (c == CharZero) begin
                     prs_base = OctBase;
                     prs_end_pos = next_pos;
                     prs_phase = PhPrefix;
                  end else begin
                     prs_base = DecBase;
                     take_digit(c, next_pos);
                  end
               end else begin
                  take_digit(c, next_pos);
               end
            end
            PhPrefix: begin
               if (c == CharLowX || c == CharUpX) begin
                  prs_base = HexBase;
                  prs_phase = PhDigits;
               end else begin
                  take_digit(c, next_pos);
               end
            end
            default: take_digit(c, next_pos);
         endcase
         prs_char_pos = next_pos;
      end
      r.value = prs_accum;
      r.end_offset = prs_end_pos;
      r.base_used = prs_base;
      r.done = (prs_phase == PhDone);
      return r;
   endfunction

   function automatic logic [CharBits-1:0] digit_char(input int unsigned d);
      if (d < 10) return CharBits'(CharZero + d);
      return CharBits'(($urandom_range(1) ? CharLowA : CharUpA) + d - 10);
   endfunction

   function automatic logic [CharBits-1:0] blank_char();
      int unsigned w;
      w = $urandom_range(8, 13);
      return (w == 8) ? CharSpace : CharBits'(w);
   endfunction

   task automatic note_failure(input string msg);
      if (fail_count < ReportLimit) $display("%s", msg);
      fail_count++;
   endtask

   // Sends one character and records the result the parser model predicts for it.
   task automatic send_char(input logic [CharBits-1:0] c, input logic first,
                            input logic [BaseBits-1:0] bsel);
      parse_result_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= {bsel, first};
      do @(posedge clock); while (!req_tready);
      sent_chars++;
      want = parse_char(c, first, bsel);
      expected_results.push_back(want);
   endtask

   // Sends run_text as one string; base_sel is random wherever it is ignored.
   task automatic send_run(input logic [BaseBits-1:0] bsel);
      for (int i = 0; i < run_text.size(); i++) begin
         send_char(run_text[i], i == 0, (i == 0) ? bsel : BaseBits'($urandom_range(63)));
      end
   endtask

   task automatic test_idle_after_reset();
      send_char("5", 1'b0, 6'd36);
      send_char(8'h00, 1'b0, 6'd63);
   endtask

   task automatic test_directed_strings();
      // Leading space, decimal digits, punctuation ends the parse.
      send_char(" ", 1'b1, DecBase);
      send_char("1", 1'b0, AutoBase);
      send_char("2", 1'b0, AutoBase);
      send_char("!", 1'b0, AutoBase);
      // Hex with prefix, ended by NUL.
      send_char("0", 1'b1, HexBase);
      send_char("x", 1'b0, AutoBase);
      send_char("1", 1'b0, AutoBase);
      send_char("F", 1'b0, AutoBase);
      send_char(8'h00, 1'b0, AutoBase);
      // Automatic base with "0X" and no digits after it.
      send_char("0", 1'b1, AutoBase);
      send_char("X", 1'b0, AutoBase);
      send_char("g", 1'b0, AutoBase);
      // Automatic base picks octal; 8 is not an octal digit.
      send_char("0", 1'b1, AutoBase);
      send_char("7", 1'b0, AutoBase);
      send_char("8", 1'b0, AutoBase);
      // Illegal bases, then a character after the end.
      send_char("A", 1'b1, UnaryBase);
      send_char("1", 1'b1, 6'd63);
      send_char("5", 1'b0, 6'd0);
      // Largest base with both letter cases, ended by the top byte value.
      send_char("z", 1'b1, MaxBase);
      send_char("Z", 1'b0, AutoBase);
      send_char(8'hFF, 1'b0, AutoBase);
      // Hex prefix zero followed by a plain digit.
      send_char("0", 1'b1, HexBase);
      send_char("9", 1'b0, AutoBase);
   endtask

   // Long enough that the position counters saturate and the value wraps.
   task automatic test_long_string();
      run_text.delete();
      repeat (200) run_text.push_back(blank_char());
      repeat (100) run_text.push_back(digit_char($urandom_range(1)));
      run_text.push_back("2");
      send_run(6'd2);
   endtask

   task automatic test_random_strings(input int unsigned target);
      int unsigned start_count;
      int unsigned pick;
      int unsigned digit_base;
      logic [BaseBits-1:0] bsel;
      start_count = sent_chars;
      while (sent_chars - start_count < target) begin
         run_text.delete();
         pick = $urandom_range(99);
         if (pick < 6) bsel = $urandom_range(1) ? UnaryBase : BaseBits'($urandom_range(37, 63));
         else if (pick < 30) bsel = AutoBase;
         else if (pick < 50) bsel = HexBase;
         else if (pick < 60) bsel = DecBase;
         else if (pick < 65) bsel = OctBase;
         else bsel = BaseBits'($urandom_range(2, 36));
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) run_text.push_back(CharBits'($urandom_range(255)));
         end else begin
            if ($urandom_range(1)) begin
               repeat ($urandom_range(1, 3)) run_text.push_back(blank_char());
            end
            digit_base = 32'((bsel == UnaryBase || bsel > MaxBase || bsel == AutoBase) ?
                             DecBase : bsel);
            if (bsel == AutoBase || bsel == HexBase) begin
               pick = $urandom_range(3);
               if (pick != 0) begin
                  run_text.push_back(CharZero);
                  digit_base = 32'((bsel == AutoBase) ? OctBase : HexBase);
               end
               if (pick >= 2) begin
                  run_text.push_back($urandom_range(1) ? CharLowX : CharUpX);
                  digit_base = 32'(HexBase);
               end
            end
            repeat ($urandom_range(12)) begin
               run_text.push_back(digit_char($urandom_range(digit_base - 1)));
            end
            case ($urandom_range(3))
               0: run_text.push_back(8'h00);
               1: run_text.push_back(blank_char());
               2: run_text.push_back(CharBits'($urandom_range(255)));
               default: run_text.push_back((digit_base < MaxBase) ? digit_char(digit_base) : "!");
            endcase
            repeat ($urandom_range(2)) run_text.push_back(CharBits'($urandom_range(255)));
         end
         send_run(bsel);
      end
   endtask

   // Result checker and receiver back-pressure.
   always @(posedge clock) begin
      parse_result_type want;
      parse_result_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.value = rsp_tdata[ValueBits-1:0];
         got.end_offset = rsp_tdata[ValueBits +: PosBits];
         got.base_used = rsp_tdata[ValueBits + PosBits +: BaseBits];
         got.done = rsp_tuser[0];
         if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected result: value %h offset %0d base %0d done %b",
                                   got.value, got.end_offset, got.base_used, got.done));
         end else begin
            want = expected_results.pop_front();
            if (got.value !== want.value || got.end_offset !== want.end_offset ||
                got.base_used !== want.base_used || got.done !== want.done) begin
               note_failure({
                  $sformatf("mismatch: expected value %h offset %0d base %0d done %b",
                            want.value, want.end_offset, want.base_used, want.done),
                  $sformatf(", got value %h offset %0d base %0d done %b",
                            got.value, got.end_offset, got.base_used, got.done)});
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      prs_phase = PhDone;
      prs_base = '0;
      prs_accum = '0;
      prs_char_pos = '0;
      prs_end_pos = '0;
      sent_chars = 0;
      fail_count = 0;
      send_idle_pct = 30;
      recv_idle_pct = 78;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      rsp_tready <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_idle_after_reset();
      test_directed_strings();
      test_random_strings(420);
      send_idle_pct = 78;
      recv_idle_pct = 30;
      test_long_string();
      test_random_strings(420);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(420);

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/untp_pkg.sv
sv/unsigned_number_text_parser_core.sv
dv/tb.sv
